/* hdl/sha1s_pkg.sv */
// ---------------------------------------------------------------------------
// sha1s_pkg: shared types and constants of the SHA-1 stream hasher
// Queue beat format, state enums, round constants and initial hash values.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1s_pkg;

  localparam int DIGEST_WORDS = 5;

  typedef logic [31:0] word_t;
  typedef logic [DIGEST_WORDS-1:0][31:0] digest_t;

  // One beat from the front to the back: a big-endian message word.
  typedef struct packed {
    word_t word;
    logic  blk_end;   // 16th word of a block
    logic  msg_end;   // last block of the message
  } q_entry_t;

  typedef enum logic [1:0] {
    F_IDLE,
    F_PAD_HEAD,
    F_PAD_BODY
  } front_state_t;

  typedef enum logic [1:0] {
    B_LOAD,
    B_ROUND,
    B_UPDATE,
    B_DIGEST
  } back_state_t;

  localparam word_t K0 = 32'h5a827999;
  localparam word_t K1 = 32'h6ed9eba1;
  localparam word_t K2 = 32'h8f1bbcdc;
  localparam word_t K3 = 32'hca62c1d6;

  localparam word_t H0 = 32'h67452301;
  localparam word_t H1 = 32'hefcdab89;
  localparam word_t H2 = 32'h98badcfe;
  localparam word_t H3 = 32'h10325476;
  localparam word_t H4 = 32'hc3d2e1f0;

  localparam digest_t IV = {H4, H3, H2, H1, H0};

  localparam logic [7:0] PAD_BYTE     = 8'h80;
  localparam logic [5:0] LEN_FIELD_AT = 6'd56;  // first byte of the length field
  localparam logic [3:0] LEN_HI_POS   = 4'd14;
  localparam logic [3:0] LEN_LO_POS   = 4'd15;
  localparam logic [2:0] LAST_INDEX   = 3'd4;

endpackage

/* hdl/sha1s_fifo.sv */
// ---------------------------------------------------------------------------
// sha1s_fifo: word queue between front and back
// Small register-file FIFO; read data is the head entry, shown combinationally.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1s_fifo #(
  parameter int AW = 2
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 wr_en,
  input  sha1s_pkg::q_entry_t  wr_data,
  output logic                 q_full,
  input  logic                 rd_en,
  output sha1s_pkg::q_entry_t  rd_data,
  output logic                 q_empty
);
  import sha1s_pkg::*;

  localparam int DEPTH = 1 << AW;

  q_entry_t        mem_r [DEPTH];
  logic [AW-1:0]   wptr_r, wptr_nxt;
  logic [AW-1:0]   rptr_r, rptr_nxt;
  logic [AW:0]     cnt_r, cnt_nxt;
  logic            do_wr, do_rd;

  assign q_full  = (cnt_r == (AW+1)'(DEPTH));
  assign q_empty = (cnt_r == '0);
  assign do_wr   = wr_en && !q_full;
  assign do_rd   = rd_en && !q_empty;
  assign rd_data = mem_r[rptr_r];

  always_comb begin
    wptr_nxt = do_wr ? wptr_r + 1'b1 : wptr_r;
    rptr_nxt = do_rd ? rptr_r + 1'b1 : rptr_r;
    cnt_nxt  = cnt_r;
    if (do_wr && !do_rd) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_rd && !do_wr) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= '0;
      rptr_r <= '0;
      cnt_r  <= '0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_wr) begin
      mem_r[wptr_r] <= wr_data;
    end
  end

endmodule

/* hdl/sha1s_front.sv */
// ---------------------------------------------------------------------------
// sha1s_front: byte intake and padding
// Packs message bytes into words, counts the message length and, at end of
// message, generates the 0x80 pad, zero fill and the 64-bit bit length.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1s_front (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 push,
  output logic                 full,
  input  logic [7:0]           in_data_byte,
  input  logic                 in_has_byte,
  input  logic                 in_end_of_message,
  output logic                 q_push,
  output sha1s_pkg::q_entry_t  q_entry,
  input  logic                 q_full
);
  import sha1s_pkg::*;

  front_state_t  state_r, state_nxt;
  logic [5:0]    fill_r;
  logic [60:0]   msg_r;
  logic [23:0]   acc_r;
  logic [3:0]    wp_r;
  logic          extra_r;

  logic          accept;
  logic [5:0]    fill_after;
  word_t         head_word;
  word_t         body_word;
  logic [63:0]   bit_len;

  assign accept     = push && !full;
  assign fill_after = fill_r + 6'(in_has_byte);
  assign bit_len    = {msg_r, 3'b000};

  always_comb begin
    case (fill_r[1:0])
      2'd0:    head_word = {PAD_BYTE, 24'h000000};
      2'd1:    head_word = {acc_r[7:0], PAD_BYTE, 16'h0000};
      2'd2:    head_word = {acc_r[15:0], PAD_BYTE, 8'h00};
      default: head_word = {acc_r[23:0], PAD_BYTE};
    endcase
  end

  always_comb begin
    body_word = '0;
    if (!extra_r && wp_r == LEN_HI_POS) begin
      body_word = bit_len[63:32];
    end else if (!extra_r && wp_r == LEN_LO_POS) begin
      body_word = bit_len[31:0];
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      F_IDLE: begin
        if (accept && in_end_of_message) begin
          state_nxt = F_PAD_HEAD;
        end
      end
      F_PAD_HEAD: begin
        if (!q_full) begin
          state_nxt = F_PAD_BODY;
        end
      end
      F_PAD_BODY: begin
        if (!q_full && wp_r == LEN_LO_POS && !extra_r) begin
          state_nxt = F_IDLE;
        end
      end
      default: state_nxt = F_IDLE;
    endcase
  end

  // outputs
  always_comb begin
    full            = 1'b1;
    q_push          = 1'b0;
    q_entry.word    = {acc_r, in_data_byte};
    q_entry.blk_end = 1'b0;
    q_entry.msg_end = 1'b0;
    case (state_r)
      F_IDLE: begin
        full            = q_full;
        q_push          = accept && in_has_byte && (fill_r[1:0] == 2'd3);
        q_entry.blk_end = (fill_r == 6'd63);
      end
      F_PAD_HEAD: begin
        q_push          = !q_full;
        q_entry.word    = head_word;
        q_entry.blk_end = (wp_r == LEN_LO_POS);
        q_entry.msg_end = (wp_r == LEN_LO_POS) && !extra_r;
      end
      F_PAD_BODY: begin
        q_push          = !q_full;
        q_entry.word    = body_word;
        q_entry.blk_end = (wp_r == LEN_LO_POS);
        q_entry.msg_end = (wp_r == LEN_LO_POS) && !extra_r;
      end
      default: begin
        full = 1'b1;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      fill_r  <= '0;
      msg_r   <= '0;
      wp_r    <= '0;
      extra_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == F_IDLE) begin
        if (accept && in_has_byte) begin
          fill_r <= fill_after;
          msg_r  <= msg_r + 61'd1;
        end
        if (accept && in_end_of_message) begin
          wp_r    <= fill_after[5:2];
          extra_r <= (fill_after >= LEN_FIELD_AT);
        end
      end else if (q_push) begin
        wp_r <= wp_r + 4'd1;
        if (wp_r == LEN_LO_POS) begin
          if (extra_r) begin
            extra_r <= 1'b0;
          end else begin
            fill_r <= '0;
            msg_r  <= '0;
          end
        end
      end
    end
  end

  // partial word: earlier bytes of the current word, newest in the low byte
  always_ff @(posedge clk) begin
    if (accept && in_has_byte) begin
      acc_r <= {acc_r[15:0], in_data_byte};
    end
  end

endmodule

/* hdl/sha1s_back.sv */
// ---------------------------------------------------------------------------
// sha1s_back: SHA-1 compression engine
// Shifts 16 words into the schedule window, runs 80 rounds at one round per
// cycle, folds the result into the chaining words and hands off the digest.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1s_back (
  input  logic                 clk,
  input  logic                 rst_n,
  input  sha1s_pkg::q_entry_t  q_entry,
  input  logic                 q_empty,
  output logic                 q_pop,
  input  logic                 out_free,
  output logic                 dig_load,
  output sha1s_pkg::digest_t   dig_words
);
  import sha1s_pkg::*;

  function automatic word_t rol(input word_t x, input int unsigned n);
    rol = (x << n) | (x >> (32 - n));
  endfunction

  back_state_t  state_r, state_nxt;
  digest_t      chain_r;
  word_t        sched_r [16];
  word_t        wa_r, wb_r, wc_r, wd_r, we_r;
  logic [6:0]   rnd_r;
  logic         msg_end_r;

  word_t        f_val, k_val, t_val, w_new;

  assign dig_words = chain_r;

  always_comb begin
    if (rnd_r inside {[7'd0:7'd19]}) begin
      f_val = (wb_r & wc_r) | (~wb_r & wd_r);
      k_val = K0;
    end else if (rnd_r inside {[7'd20:7'd39]}) begin
      f_val = wb_r ^ wc_r ^ wd_r;
      k_val = K1;
    end else if (rnd_r inside {[7'd40:7'd59]}) begin
      f_val = (wb_r & wc_r) | (wb_r & wd_r) | (wc_r & wd_r);
      k_val = K2;
    end else begin
      f_val = wb_r ^ wc_r ^ wd_r;
      k_val = K3;
    end
  end

  // window holds W[t..t+15]; the new tap is W[t+16]
  assign w_new = rol(sched_r[13] ^ sched_r[8] ^ sched_r[2] ^ sched_r[0], 1);
  assign t_val = rol(wa_r, 5) + f_val + we_r + k_val + sched_r[0];

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      B_LOAD: begin
        if (!q_empty && q_entry.blk_end) begin
          state_nxt = B_ROUND;
        end
      end
      B_ROUND: begin
        if (rnd_r == 7'd79) begin
          state_nxt = B_UPDATE;
        end
      end
      B_UPDATE: state_nxt = msg_end_r ? B_DIGEST : B_LOAD;
      B_DIGEST: begin
        if (out_free) begin
          state_nxt = B_LOAD;
        end
      end
      default: state_nxt = B_LOAD;
    endcase
  end

  // outputs
  always_comb begin
    q_pop    = 1'b0;
    dig_load = 1'b0;
    case (state_r)
      B_LOAD:   q_pop = !q_empty;
      B_DIGEST: dig_load = out_free;
      default: begin
        q_pop    = 1'b0;
        dig_load = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= B_LOAD;
      chain_r   <= IV;
      rnd_r     <= '0;
      msg_end_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      case (state_r)
        B_LOAD: begin
          if (!q_empty && q_entry.blk_end) begin
            msg_end_r <= q_entry.msg_end;
            rnd_r     <= '0;
          end
        end
        B_ROUND: rnd_r <= rnd_r + 7'd1;
        B_UPDATE: begin
          chain_r[0] <= chain_r[0] + wa_r;
          chain_r[1] <= chain_r[1] + wb_r;
          chain_r[2] <= chain_r[2] + wc_r;
          chain_r[3] <= chain_r[3] + wd_r;
          chain_r[4] <= chain_r[4] + we_r;
        end
        B_DIGEST: begin
          if (out_free) begin
            chain_r <= IV;
          end
        end
        default: rnd_r <= '0;
      endcase
    end
  end

  // schedule window and working words
  always_ff @(posedge clk) begin
    if (state_r == B_LOAD && !q_empty) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= q_entry.word;
      if (q_entry.blk_end) begin
        wa_r <= chain_r[0];
        wb_r <= chain_r[1];
        wc_r <= chain_r[2];
        wd_r <= chain_r[3];
        we_r <= chain_r[4];
      end
    end else if (state_r == B_ROUND) begin
      for (int i = 0; i < 15; i++) begin
        sched_r[i] <= sched_r[i+1];
      end
      sched_r[15] <= w_new;
      wa_r <= t_val;
      wb_r <= wa_r;
      wc_r <= rol(wb_r, 30);
      wd_r <= wc_r;
      we_r <= wd_r;
    end
  end

endmodule

/* hdl/sha1s_digest_out.sv */
// ---------------------------------------------------------------------------
// sha1s_digest_out: digest result stage
// Holds one finished digest and presents it word by word, first word first.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1s_digest_out (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                dig_load,
  input  sha1s_pkg::digest_t  dig_words,
  output logic                out_free,
  output logic                empty,
  input  logic                pop,
  output logic [31:0]         out_digest_word,
  output logic [2:0]          out_word_index,
  output logic                out_last_word
);
  import sha1s_pkg::*;

  digest_t     words_r;
  logic [2:0]  cnt_r;
  logic [2:0]  idx_r;
  logic        do_pop;

  assign empty           = (cnt_r == '0);
  assign out_free        = empty;
  assign do_pop          = pop && !empty;
  assign out_digest_word = words_r[0];
  assign out_word_index  = idx_r;
  assign out_last_word   = (idx_r == LAST_INDEX);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
      idx_r <= '0;
    end else if (dig_load) begin
      cnt_r <= 3'(DIGEST_WORDS);
      idx_r <= '0;
    end else if (do_pop) begin
      cnt_r <= cnt_r - 3'd1;
      idx_r <= idx_r + 3'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (dig_load) begin
      words_r <= dig_words;
    end else if (do_pop) begin
      words_r <= {32'h0, words_r[DIGEST_WORDS-1:1]};
    end
  end

endmodule

/* hdl/sha1_stream_hasher_core.sv */
// ---------------------------------------------------------------------------
// sha1_stream_hasher_core: SHA-1 hasher, one message byte per input beat
// Output: digest word 0 appears once the last padded block is folded (B_UPDATE) and handed off (B_DIGEST).
// Throughput: 1 byte/cycle until the queue fills; input is held off while the front pads a message end.
// Reset: synchronous; counters, queues cleared, chaining words to IV, no clearing pass.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_stream_hasher_core #(
  parameter int QUEUE_AW = 2
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_has_byte,
  input  logic        in_end_of_message,
  output logic        empty,
  input  logic        pop,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);
  import sha1s_pkg::*;

  // The front takes a beat per cycle while the queue has room and, after end of
  // message, pads out the rest of one or two blocks with input held off; for
  // each block the back loads 16 words, runs the rounds and folds the result.
  // With a 4-word queue the rounds absorb 16 bytes, so loading the other 48 is
  // paced by intake when bytes come every cycle.

  q_entry_t  f_entry, b_entry;
  logic      q_push, q_full, q_pop, q_empty;
  logic      out_free, dig_load;
  digest_t   dig_words;

  sha1s_front u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .push              (push),
    .full              (full),
    .in_data_byte      (in_data_byte),
    .in_has_byte       (in_has_byte),
    .in_end_of_message (in_end_of_message),
    .q_push            (q_push),
    .q_entry           (f_entry),
    .q_full            (q_full)
  );

  sha1s_fifo #(
    .AW (QUEUE_AW)
  ) u_fifo (
    .clk     (clk),
    .rst_n   (rst_n),
    .wr_en   (q_push),
    .wr_data (f_entry),
    .q_full  (q_full),
    .rd_en   (q_pop),
    .rd_data (b_entry),
    .q_empty (q_empty)
  );

  sha1s_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_entry   (b_entry),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .out_free  (out_free),
    .dig_load  (dig_load),
    .dig_words (dig_words)
  );

  sha1s_digest_out u_out (
    .clk             (clk),
    .rst_n           (rst_n),
    .dig_load        (dig_load),
    .dig_words       (dig_words),
    .out_free        (out_free),
    .empty           (empty),
    .pop             (pop),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

`ifndef SYNTHESIS
  a_no_push_when_full: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_full)
    else $error("front pushed into a full queue");

  a_no_pop_when_empty: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_empty)
    else $error("back popped an empty queue");

  a_pad_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
    (push && !full && in_end_of_message) |=> full)
    else $error("input not held off while padding");

  a_digest_wraps: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && !empty && out_last_word) |=> (empty || out_word_index == 3'd0))
    else $error("digest word index did not restart");

  a_load_into_free: assert property (@(posedge clk) disable iff (!rst_n)
    dig_load |-> empty)
    else $error("digest loaded over a pending digest");
`endif

endmodule
